[sv/qmdh_pkg.sv]
package qmdh_pkg;

    localparam int IN_W      = 80;
    localparam int FUNC_W    = 2;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 38;
    localparam int FRAC      = 28;
    localparam int PIX_SHIFT = 44;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_TRACE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW     = 3'd7;

    localparam logic [31:0] RST_COEF_A = 32'd34896609;
    localparam logic [31:0] RST_COEF_B = 32'd24159191;
    localparam logic [31:0] RST_ORIGIN = 32'hE000_0000;
    localparam logic [31:0] RST_SCALE  = 32'd4194304;
    localparam logic [9:0]  RST_SETTLE = 10'd10;
    localparam logic [12:0] RST_DRAW   = 13'd4000;

    localparam logic [12:0] DRAW_MAX   = 13'd4096;
    localparam logic [33:0] SHADE_FULL = 34'd65025;
    localparam logic [7:0]  SHADE_TOP  = 8'd255;

    typedef logic signed [ACC_W-1:0] t_acc;

    function automatic t_acc fl28(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC;
        return s[ACC_W-1:0];
    endfunction

    // {escape, saturated value}
    function automatic logic [32:0] sat32(input t_acc v);
        logic [32:0] r;
        if (v >= t_acc'(64'sh8000_0000)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v <= -t_acc'(64'sh8000_0000)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[sv/qmdh_mul.sv]
module qmdh_mul (
    input  logic                                 i_clk,
    input  logic signed [qmdh_pkg::MUL_W-1:0]    i_a,
    input  logic signed [qmdh_pkg::MUL_W-1:0]    i_b,
    output logic signed [qmdh_pkg::PROD_W-1:0]   o_p
);
    import qmdh_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[sv/qmdh_store.sv]
module qmdh_store #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/quadratic_map_density_histogram.sv]
// channel   dir  fields (low bit first)
// s_axis    in   tuser func[1:0]
//                tdata seed_x[31:0] seed_y[63:32] pixel_col[71:64] pixel_row[79:72]
// m_axis    out  tdata shade[7:0] hit_count[23:8] plotted[36:24]
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// One shared 34x34 multiplier does all multiplication. A map step runs states
// M0 to M4; a plotted step adds P0 to P2 for the pixel index and P3 for the
// histogram update. A pixel read runs RD and LIM, then TT, SQ and CMP per shade bit.
// Reset and a clear sweep all 2**(2*clog2(SIDE)) store entries, one entry a cycle.
// Input is taken only while idle; a finished result waits for the output slot.
module quadratic_map_density_histogram #(
    parameter int SIDE       = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [qmdh_pkg::IN_W-1:0]         i_s_axis_tdata,   // seed_x seed_y col row
    input  logic [qmdh_pkg::FUNC_W-1:0]       i_s_axis_tuser,   // func
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [qmdh_pkg::OUT_W-1:0]        o_m_axis_tdata,   // shade hit_count plotted
    input  logic                              i_cfg_we,
    input  logic [qmdh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qmdh_pkg::CFG_W-1:0]        i_cfg_data
);
    import qmdh_pkg::*;

    localparam int IW = $clog2(SIDE);
    localparam int AW = 2 * IW;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001, S_CLR  = 18'h00002, S_M0  = 18'h00004,
        S_M1   = 18'h00008, S_M2   = 18'h00010, S_M3  = 18'h00020,
        S_M4   = 18'h00040, S_P0   = 18'h00080, S_P1  = 18'h00100,
        S_P2   = 18'h00200, S_P3   = 18'h00400, S_RD  = 18'h00800,
        S_LIM  = 18'h01000, S_TT   = 18'h02000, S_SQ  = 18'h04000,
        S_CMP  = 18'h08000, S_OUT  = 18'h10000, S_SPARE = 18'h20000
    } t_state;

    t_state r_state;

    logic [31:0] r_coef_a, r_coef_b, r_origin_x, r_origin_y, r_scale_x, r_scale_y;
    logic [9:0]  r_settle;
    logic [12:0] r_draw_steps;

    logic [31:0] r_x, r_y;
    t_acc        r_ax, r_ay;
    logic        r_esc, r_draw, r_negx, r_negy, r_okx, r_rd_ok, r_clr_res, r_ovalid;
    logic [1:0]  r_sub;
    logic [7:0]  r_grp;
    logic [12:0] r_cnt, r_plot;
    logic [IW-1:0] r_qx;
    logic [AW-1:0] r_paddr, r_caddr;
    logic [28:0] r_lim;
    logic [7:0]  r_k, r_shade;
    logic [2:0]  r_bit;
    logic [15:0] r_hit;
    logic [OUT_W-1:0] r_odata;

    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] w_p;
    t_acc        w_fl;
    logic [32:0] w_satx, w_saty;
    logic        w_esc;
    logic [12:0] w_deff;
    logic [7:0]  w_groups;
    logic [32:0] w_dx, w_dy, w_magx, w_magy;
    logic [23:0] w_q;
    logic        w_qok_x, w_qok_y, w_pix_ok;
    logic [1:0]  w_func;
    logic [7:0]  w_col, w_row;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [COUNT_BITS-1:0] w_wdata, w_rdata, w_cnt;
    logic [31:0] w_c32;
    logic [12:0] w_cmin;
    logic [7:0]  w_t, w_k_new;

    assign w_func = i_s_axis_tuser;
    assign w_col  = i_s_axis_tdata[71:64];
    assign w_row  = i_s_axis_tdata[79:72];

    assign w_deff = (r_draw_steps == 13'd0) ? 13'd1 :
                    (r_draw_steps > DRAW_MAX) ? DRAW_MAX : r_draw_steps;
    assign w_groups = r_settle[9:2];

    assign w_fl   = fl28(w_p);
    assign w_satx = sat32(r_ax);
    assign w_saty = sat32(r_ay + w_fl);
    assign w_esc  = r_esc | w_satx[32] | w_saty[32];

    assign w_dx   = {r_x[31], r_x} - {r_origin_x[31], r_origin_x};
    assign w_dy   = {r_y[31], r_y} - {r_origin_y[31], r_origin_y};
    assign w_magx = w_dx[32] ? (33'd0 - w_dx) : w_dx;
    assign w_magy = w_dy[32] ? (33'd0 - w_dy) : w_dy;
    assign w_q    = w_p[PROD_W-1:PIX_SHIFT];
    assign w_qok_x  = (!r_negx || w_q == 24'd0) && (w_q < 24'(SIDE));
    assign w_qok_y  = (!r_negy || w_q == 24'd0) && (w_q < 24'(SIDE));
    assign w_pix_ok = r_okx && w_qok_y;

    assign w_cnt  = r_rd_ok ? w_rdata : '0;
    assign w_c32  = 32'(w_cnt);
    assign w_cmin = (w_c32 < 32'(w_deff)) ? w_c32[12:0] : w_deff;
    assign w_t    = r_k | (8'd1 << r_bit);
    assign w_k_new = (w_p[29:0] <= {1'b0, r_lim}) ? w_t : r_k;

    always_comb begin
        case (r_state)
            S_M0:    begin w_ma = {{2{r_coef_a[31]}}, r_coef_a}; w_mb = {{2{r_x[31]}}, r_x}; end
            S_M1:    begin w_ma = {{2{r_y[31]}}, r_y};           w_mb = {{2{r_y[31]}}, r_y}; end
            S_M2:    begin w_ma = {{2{r_coef_b[31]}}, r_coef_b}; w_mb = {{2{r_y[31]}}, r_y}; end
            S_M3:    begin w_ma = {{2{r_x[31]}}, r_x};           w_mb = {{2{r_y[31]}}, r_y}; end
            S_P0:    begin w_ma = {1'b0, w_magx}; w_mb = {2'b0, r_scale_x}; end
            S_P1:    begin w_ma = {1'b0, w_magy}; w_mb = {2'b0, r_scale_y}; end
            S_RD:    begin w_ma = SHADE_FULL;     w_mb = {21'd0, w_cmin}; end
            S_TT:    begin w_ma = {26'd0, w_t};   w_mb = {26'd0, w_t}; end
            S_SQ:    begin w_ma = {18'd0, w_p[15:0]}; w_mb = {21'd0, w_deff}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_we    = (r_state == S_CLR) || (r_state == S_P3);
    assign w_waddr = (r_state == S_CLR) ? r_caddr : r_paddr;
    assign w_wdata = (r_state == S_CLR) ? '0 : ((&w_rdata) ? w_rdata : w_rdata + 1'b1);
    assign w_raddr = (r_state == S_IDLE) ? {IW'(w_row), IW'(w_col)} : {w_q[IW-1:0], r_qx};

    qmdh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    qmdh_store #(.AW(AW), .DW(COUNT_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_caddr      <= '0;
            r_clr_res    <= 1'b0;
            r_ovalid     <= 1'b0;
            r_coef_a     <= RST_COEF_A;
            r_coef_b     <= RST_COEF_B;
            r_origin_x   <= RST_ORIGIN;
            r_origin_y   <= RST_ORIGIN;
            r_scale_x    <= RST_SCALE;
            r_scale_y    <= RST_SCALE;
            r_settle     <= RST_SETTLE;
            r_draw_steps <= RST_DRAW;
            r_x          <= '0;
            r_y          <= '0;
            r_plot       <= '0;
            r_cnt        <= '0;
            r_draw       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COEF_A:   r_coef_a     <= i_cfg_data;
                    CFG_COEF_B:   r_coef_b     <= i_cfg_data;
                    CFG_ORIGIN_X: r_origin_x   <= i_cfg_data;
                    CFG_ORIGIN_Y: r_origin_y   <= i_cfg_data;
                    CFG_SCALE_X:  r_scale_x    <= i_cfg_data;
                    CFG_SCALE_Y:  r_scale_y    <= i_cfg_data;
                    CFG_SETTLE:   r_settle     <= i_cfg_data[9:0];
                    CFG_DRAW:     r_draw_steps <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (&r_caddr) begin
                        r_state <= r_clr_res ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_shade <= '0;
                        r_hit   <= '0;
                        r_plot  <= '0;
                        case (w_func)
                            FUNC_CLEAR: begin
                                r_clr_res <= 1'b1;
                                r_caddr   <= '0;
                                r_state   <= S_CLR;
                            end
                            FUNC_TRACE: begin
                                r_x     <= i_s_axis_tdata[31:0];
                                r_y     <= i_s_axis_tdata[63:32];
                                r_esc   <= 1'b0;
                                r_sub   <= '0;
                                r_grp   <= '0;
                                r_cnt   <= '0;
                                r_draw  <= (w_groups == 8'd0);
                                r_state <= S_M0;
                            end
                            FUNC_READ: begin
                                r_rd_ok <= (32'(w_col) < 32'(SIDE)) && (32'(w_row) < 32'(SIDE));
                                r_state <= S_RD;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_ax    <= w_fl;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_ax    <= r_ax - w_fl;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_ay    <= w_fl;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_x   <= w_satx[31:0];
                    r_y   <= w_saty[31:0];
                    r_esc <= w_esc;
                    if (!r_draw) begin
                        r_sub <= r_sub + 2'd1;
                        if (r_sub == 2'd3) begin
                            if (w_esc) begin
                                r_state <= S_OUT;
                            end else if (r_grp == w_groups - 8'd1) begin
                                r_draw  <= 1'b1;
                                r_state <= S_M0;
                            end else begin
                                r_grp   <= r_grp + 8'd1;
                                r_state <= S_M0;
                            end
                        end else begin
                            r_state <= S_M0;
                        end
                    end else if (w_esc) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_P0;
                    end
                end
                S_P0: begin
                    r_negx  <= w_dx[32];
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_negy  <= w_dy[32];
                    r_okx   <= w_qok_x;
                    r_qx    <= w_q[IW-1:0];
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_paddr <= {w_q[IW-1:0], r_qx};
                    if (w_pix_ok) begin
                        r_state <= S_P3;
                    end else if (r_cnt == w_deff - 13'd1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 13'd1;
                        r_state <= S_M0;
                    end
                end
                S_P3: begin
                    r_plot <= r_plot + 13'd1;
                    if (r_cnt == w_deff - 13'd1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 13'd1;
                        r_state <= S_M0;
                    end
                end
                S_RD: begin
                    r_hit   <= (|w_c32[31:16]) ? 16'hFFFF : w_c32[15:0];
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_lim   <= w_p[28:0];
                    r_k     <= '0;
                    r_bit   <= 3'd7;
                    r_state <= S_TT;
                end
                S_TT: r_state <= S_SQ;
                S_SQ: r_state <= S_CMP;
                S_CMP: begin
                    r_k <= w_k_new;
                    if (r_bit == 3'd0) begin
                        r_shade <= SHADE_TOP - w_k_new;
                        r_state <= S_OUT;
                    end else begin
                        r_bit   <= r_bit - 3'd1;
                        r_state <= S_TT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid  <= 1'b1;
                        r_odata   <= {3'd0, r_plot, r_hit, r_shade};
                        r_clr_res <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_draw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0 && r_draw) |-> (r_cnt < w_deff))
        else $error("draw step count beyond limit");

    a_plot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0 && r_draw) |-> (r_plot <= r_cnt))
        else $error("plotted exceeds steps taken");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result beat raised outside output state");
`endif

endmodule

[tb/quadratic_map_density_histogram_tb.sv]
`timescale 1ns / 100ps

module quadratic_map_density_histogram_tb;
    import qmdh_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] seed_x;
        logic signed [31:0] seed_y;
        logic [7:0]         col;
        logic [7:0]         row;
    } t_req;

    typedef struct {
        logic [7:0]  shade;
        logic [15:0] hits;
        logic [12:0] plotted;
    } t_rsp;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_valid;
    logic               s_ready;
    logic [IN_W-1:0]    s_data;
    logic [FUNC_W-1:0]  s_user;
    logic               m_valid;
    logic               m_ready;
    logic [OUT_W-1:0]   m_data;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    quadratic_map_density_histogram u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // shadow of the block's registers and store
    logic signed [31:0] m_coef_a, m_coef_b, m_org_x, m_org_y;
    logic [31:0]        m_scl_x, m_scl_y;
    logic [9:0]         m_settle;
    logic [12:0]        m_draw;
    logic [15:0]        hit_mem [0:65535];
    int                 hit_pixels[$];

    t_req pend_q[$];
    t_rsp result_q[$];
    t_req cur_req;
    int   n_errors, n_traces, n_reads, n_plotted, n_results;
    int   burst_left, gap_left;
    int   rdy_cnt;
    bit   fire;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("quadratic_map_density_histogram_tb: errors");
        $finish;
    end

    function automatic int draw_eff();
        if (m_draw == 0) return 1;
        if (m_draw > DRAW_MAX) return int'(DRAW_MAX);
        return int'(m_draw);
    endfunction

    function automatic void map_advance(inout longint px, inout longint py, inout bit esc);
        longint nx, ny;
        nx = ((longint'(m_coef_a) * px) >>> 28) - ((py * py) >>> 28);
        ny = ((longint'(m_coef_b) * py) >>> 28) + ((px * py) >>> 28);
        if (nx >= 64'sh8000_0000) begin nx = 64'sh7FFF_FFFF; esc = 1; end
        else if (nx <= -64'sh8000_0000) begin nx = -64'sh8000_0000; esc = 1; end
        if (ny >= 64'sh8000_0000) begin ny = 64'sh7FFF_FFFF; esc = 1; end
        else if (ny <= -64'sh8000_0000) begin ny = -64'sh8000_0000; esc = 1; end
        px = nx;
        py = ny;
    endfunction

    function automatic bit pixel_of(longint coord, logic signed [31:0] org,
                                    logic [31:0] scl, output int idx);
        longint       d;
        logic [63:0]  mag;
        logic [127:0] q;
        d   = coord - longint'(org);
        mag = (d < 0) ? -d : d;
        q   = ({64'b0, mag} * {96'b0, scl}) >> 44;
        idx = 0;
        if (d < 0 && q != 0) return 0;
        if (q >= 256) return 0;
        idx = int'(q);
        return 1;
    endfunction

    function automatic int trace_points(logic signed [31:0] sx, logic signed [31:0] sy);
        longint px, py;
        bit     esc;
        int     cx, cy, k, cnt;
        px = longint'(sx);
        py = longint'(sy);
        esc = 0;
        cnt = 0;
        for (int g = 0; g < (m_settle >> 2); g++) begin
            for (int s = 0; s < 4; s++) map_advance(px, py, esc);
            if (esc) return 0;
        end
        for (int i = 0; i < draw_eff(); i++) begin
            map_advance(px, py, esc);
            if (esc) break;
            if (pixel_of(px, m_org_x, m_scl_x, cx) && pixel_of(py, m_org_y, m_scl_y, cy)) begin
                k = cy * 256 + cx;
                if (hit_mem[k] == 0) hit_pixels.push_back(k);
                if (hit_mem[k] != 16'hFFFF) hit_mem[k]++;
                cnt++;
            end
        end
        return cnt;
    endfunction

    function automatic logic [7:0] shade_of(logic [15:0] cnt);
        longint d, c;
        int     k;
        d = draw_eff();
        c = (cnt < d) ? cnt : d;
        k = 0;
        while (k < 255 && longint'(k + 1) * (k + 1) * d <= 65025 * c) k++;
        return 8'(255 - k);
    endfunction

    function automatic void predict(t_req r);
        t_rsp e;
        e = '{8'd0, 16'd0, 13'd0};
        case (r.func)
            FUNC_CLEAR: begin
                foreach (hit_mem[i]) hit_mem[i] = 0;
                hit_pixels.delete();
            end
            FUNC_TRACE: begin
                e.plotted = 13'(trace_points(r.seed_x, r.seed_y));
                n_traces++;
                n_plotted += e.plotted;
            end
            FUNC_READ: begin
                e.hits  = hit_mem[{r.row, r.col}];
                e.shade = shade_of(e.hits);
                n_reads++;
            end
            default: ;
        endcase
        result_q.push_back(e);
    endfunction

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            s_user     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) predict(cur_req);
            if (!s_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_req = pend_q.pop_front();
                    s_data  <= {cur_req.row, cur_req.col, cur_req.seed_y, cur_req.seed_x};
                    s_user  <= cur_req.func;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: phases of always-ready, coin flip, and sparse ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rdy_cnt <= 0;
        end else begin
            rdy_cnt <= rdy_cnt + 1;
            case ((rdy_cnt >> 9) % 3)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && m_valid && m_ready) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                n_errors++;
            end else begin
                e = result_q.pop_front();
                if (m_data[7:0] !== e.shade) begin
                    $error("shade: expected %0d, got %0d", e.shade, m_data[7:0]);
                    n_errors++;
                end
                if (m_data[23:8] !== e.hits) begin
                    $error("hit_count: expected %0d, got %0d", e.hits, m_data[23:8]);
                    n_errors++;
                end
                if (m_data[36:24] !== e.plotted) begin
                    $error("plotted: expected %0d, got %0d", e.plotted, m_data[36:24]);
                    n_errors++;
                end
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_COEF_A:   m_coef_a = val;
            CFG_COEF_B:   m_coef_b = val;
            CFG_ORIGIN_X: m_org_x  = val;
            CFG_ORIGIN_Y: m_org_y  = val;
            CFG_SCALE_X:  m_scl_x  = val;
            CFG_SCALE_Y:  m_scl_y  = val;
            CFG_SETTLE:   m_settle = val[9:0];
            CFG_DRAW:     m_draw   = val[12:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push(logic [1:0] f, logic [31:0] sx, logic [31:0] sy,
                        logic [7:0] c, logic [7:0] r);
        t_req q;
        q = '{f, sx, sy, c, r};
        pend_q.push_back(q);
    endtask

    // drain: wait until every queued item is sent and every expected result is back
    task automatic drain();
        while (pend_q.size() != 0 || s_valid || result_q.size() != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_seed();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
    endfunction

    task automatic random_items(int n);
        int k, sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                push(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if (sel < 50) begin
                push(FUNC_TRACE, near_seed(), near_seed(), $urandom, $urandom);
            end else if (sel < 92) begin
                if (hit_pixels.size() > 0 && $urandom_range(0, 9) < 7) begin
                    k = hit_pixels[$urandom_range(0, hit_pixels.size() - 1)];
                    push(FUNC_READ, $urandom, $urandom, k[7:0], k[15:8]);
                end else begin
                    push(FUNC_READ, $urandom, $urandom, $urandom, $urandom);
                end
            end else begin
                push(FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        n_errors = 0;
        n_traces = 0;
        n_reads  = 0;
        n_plotted = 0;
        n_results = 0;
        m_coef_a = RST_COEF_A;
        m_coef_b = RST_COEF_B;
        m_org_x  = RST_ORIGIN;
        m_org_y  = RST_ORIGIN;
        m_scl_x  = RST_SCALE;
        m_scl_y  = RST_SCALE;
        m_settle = RST_SETTLE;
        m_draw   = RST_DRAW;
        foreach (hit_mem[i]) hit_mem[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // defaults, short traces
        cfg_write(CFG_DRAW, 32'd16);
        push(FUNC_READ, 0, 0, 8'd0, 8'd0);
        push(FUNC_READ, 0, 0, 8'd255, 8'd255);
        push(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        push(FUNC_TRACE, 0, 0, 0, 0);
        push(FUNC_TRACE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        push(FUNC_TRACE, 32'h1000_0000, 32'h0800_0000, 0, 0);
        push(FUNC_READ, 0, 0, 8'd128, 8'd128);
        push(FUNC_CLEAR, 0, 0, 0, 0);
        push(FUNC_READ, 0, 0, 8'd128, 8'd128);
        drain();

        // register extremes; draw of zero acts as one
        cfg_write(CFG_COEF_A, 32'h7FFF_FFFF);
        cfg_write(CFG_COEF_B, 32'h8000_0000);
        cfg_write(CFG_ORIGIN_X, 32'h8000_0000);
        cfg_write(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
        cfg_write(CFG_SCALE_X, 32'hFFFF_FFFF);
        cfg_write(CFG_SCALE_Y, 32'h0);
        cfg_write(CFG_SETTLE, 32'd0);
        cfg_write(CFG_DRAW, 32'd0);
        push(FUNC_TRACE, 32'h0100_0000, 32'h0100_0000, 0, 0);
        push(FUNC_READ, 0, 0, 8'd0, 8'd0);
        drain();
        // escape while drawing
        cfg_write(CFG_DRAW, 32'd8);
        cfg_write(CFG_ORIGIN_Y, 32'hE000_0000);
        push(FUNC_TRACE, 32'h0100_0000, 32'h0100_0000, 0, 0);
        push(FUNC_TRACE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        push(FUNC_READ, 0, 0, 8'd0, 8'd0);
        drain();

        // largest settle, draw above the cap
        cfg_write(CFG_COEF_A, RST_COEF_A);
        cfg_write(CFG_COEF_B, RST_COEF_B);
        cfg_write(CFG_ORIGIN_X, RST_ORIGIN);
        cfg_write(CFG_ORIGIN_Y, RST_ORIGIN);
        cfg_write(CFG_SCALE_X, RST_SCALE);
        cfg_write(CFG_SCALE_Y, RST_SCALE);
        cfg_write(CFG_SETTLE, 32'd1023);
        cfg_write(CFG_DRAW, 32'd5000);
        push(FUNC_TRACE, 32'h0199_9999, 32'hFE66_6667, 0, 0);
        push(FUNC_READ, 0, 0, 8'd128, 8'd128);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(CFG_COEF_A, $urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
            cfg_write(CFG_COEF_B, $urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
            cfg_write(CFG_ORIGIN_X, 32'hE000_0000 + $urandom_range(0, 32'h0400_0000));
            cfg_write(CFG_ORIGIN_Y, 32'hE000_0000 + $urandom_range(0, 32'h0400_0000));
            cfg_write(CFG_SCALE_X, $urandom_range(32'h0040_0000, 32'h0080_0000));
            cfg_write(CFG_SCALE_Y, $urandom_range(32'h0040_0000, 32'h0080_0000));
            cfg_write(CFG_SETTLE, $urandom_range(0, 40));
            cfg_write(CFG_DRAW, $urandom_range(1, 64));
            random_items(30);
            drain();
        end

        // counter saturation: everything lands on pixel (0,0)
        cfg_write(CFG_COEF_A, 32'h0);
        cfg_write(CFG_COEF_B, 32'h0);
        cfg_write(CFG_SCALE_X, 32'h0);
        cfg_write(CFG_SCALE_Y, 32'h0);
        cfg_write(CFG_SETTLE, 32'd0);
        cfg_write(CFG_DRAW, DRAW_MAX);
        for (int i = 0; i < 17; i++) push(FUNC_TRACE, 0, 0, 0, 0);
        push(FUNC_READ, 0, 0, 8'd0, 8'd0);
        push(FUNC_READ, 0, 0, 8'd1, 8'd0);
        drain();

        $display("covered %0d traces (%0d points plotted) and %0d pixel reads, %0d results",
                 n_traces, n_plotted, n_reads, n_results);
        $display("register extremes, escapes in both phases and counter saturation included");
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("quadratic_map_density_histogram_tb: clean");
        end else begin
            $display("quadratic_map_density_histogram_tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
sv/qmdh_pkg.sv
sv/qmdh_mul.sv
sv/qmdh_store.sv
sv/quadratic_map_density_histogram.sv
tb/quadratic_map_density_histogram_tb.sv
